FILE: hw/rtl/mmp_pkg.sv
// Shared constants and types of the modular matrix power block.
`default_nettype none

package mmp_pkg;

   localparam int MAX_DIM_DEFAULT = 16;

   localparam int OP_W    = 2;
   localparam int POS_W   = 4;
   localparam int ELEM_W  = 30;
   localparam int EXP_W   = 32;
   localparam int SIZE_W  = 5;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [ELEM_W-1:0] MODULUS = 30'd1000000007;

   // Barrett reciprocal floor(2^60 / MODULUS), 31 bits.
   localparam logic [30:0] BARRETT_MU = 31'((64'd1 << 60) / 64'd1000000007);

   typedef enum logic [OP_W-1:0] {
      OP_LOAD = 2'd0,
      OP_RUN  = 2'd1,
      OP_READ = 2'd2,
      OP_NONE = 2'd3
   } op_type;

endpackage

`default_nettype wire

FILE: hw/rtl/mmp_req_if.sv
// Request channel interface of the modular matrix power block.
`default_nettype none

interface mmp_req_if import mmp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   op;
   logic [POS_W-1:0]  row;
   logic [POS_W-1:0]  col;
   logic [ELEM_W-1:0] element_value;
   logic [EXP_W-1:0]  exponent;

   modport source (output valid, output op, output row, output col,
                   output element_value, output exponent, input ready);
   modport sink   (input valid, input op, input row, input col,
                   input element_value, input exponent, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/mmp_rsp_if.sv
// Response channel interface of the modular matrix power block.
`default_nettype none

interface mmp_rsp_if import mmp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ELEM_W-1:0] result_value;
   logic              is_read_data;

   modport source (output valid, output result_value, output is_read_data, input ready);
   modport sink   (input valid, input result_value, input is_read_data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/modular_matrix_power.sv
// Top level of the modular matrix power block: channels, register port and sequencer.
//
// Use: requests arrive on req_chan; each accepted transaction yields exactly one
// response transaction on rsp_chan, in order. op 0 loads one base element, op 1
// raises the top-left n x n base matrix to the given exponent modulo 1000000007,
// op 2 reads one element of the result, op 3 does nothing. n comes from the
// matrix_size register on the APB-style csr_ port (byte address 0).
// A load, an unused op, or a read of an element known to be identity answers
// in the cycle after acceptance; a read from storage goes through the memory
// read register and the ST_RD_WAIT state first. Each matrix multiply of a run
// walks i, j, k on one shared modular multiplier and then copies the product
// back; there are popcount(exponent) + bitlength(exponent) multiplies, with one
// check of the exponent per bit and one more before the answer.
// Loads, unused ops and identity reads sustain one transaction per cycle while the
// receiver takes responses; a storage read holds the request side in ST_RD_WAIT.
// The block takes no new request while a run or a storage read is in progress.
// Reset (synchronous, active high) sets matrix_size to 16 and makes the result
// read as the identity; base elements are undefined until loaded.
// When the receiver stalls, the response is held in its output register and a
// new request is still taken if that register is freed in the same cycle.
`default_nettype none

module modular_matrix_power import mmp_pkg::*; #(
   parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   mmp_req_if.sink                    req_chan,
   mmp_rsp_if.source                  rsp_chan,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int DW = $clog2(MAX_DIM + 1);
   localparam int AW = 2 + 2 * IW;
   localparam logic CSR_IDX_MATRIX_SIZE = 1'b0;

   typedef enum logic [1:0] {
      REG_BASE    = 2'd0,
      REG_POWER   = 2'd1,
      REG_RESULT  = 2'd2,
      REG_SCRATCH = 2'd3
   } region_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD_WAIT,
      ST_RUN_CHECK,
      ST_MM_RD,
      ST_MM_MUL,
      ST_MM_WAIT,
      ST_CP_RD,
      ST_CP_WR
   } state_type;

   state_type         state_ff;
   logic [SIZE_W-1:0] size_ff;
   logic              id_flag_ff;   // result reads as the identity
   logic              pow_base_ff;  // running power still equals the base matrix
   logic              mm_res_ff;    // current multiply is result times power
   logic [EXP_W-1:0]  ex_ff;
   logic [DW-1:0]     run_dim_ff;
   logic [IW-1:0]     i_ff, j_ff, k_ff;
   logic [ELEM_W-1:0] acc_ff;
   logic              rsp_valid_ff;
   logic [ELEM_W-1:0] rsp_value_ff;
   logic              rsp_is_read_ff;

   logic [DW-1:0]     eff_dim;
   logic              accept;
   logic              rsp_set;
   logic              load_hit;
   logic              read_hit;
   logic              read_ident;
   logic              i_last, j_last, k_last;
   logic [ELEM_W-1:0] load_value;
   logic [ELEM_W-1:0] opa;
   logic [ELEM_W:0]   acc_sum;
   logic [ELEM_W-1:0] acc_next;
   logic              mul_start, mul_done;
   logic [ELEM_W-1:0] mul_res;
   logic              wr_en;
   logic [AW-1:0]     wr_addr, rd_addr_a, rd_addr_b;
   logic [ELEM_W-1:0] wr_data, rd_data_a, rd_data_b;
   logic [IW-1:0]     req_r, req_c;

   // A power operand is served from the base region until the first squaring
   // has written the power region.
   function automatic logic [1:0] phys_region(input region_type rg, input logic from_base);
      phys_region = (rg == REG_POWER && from_base) ? 2'(REG_BASE) : 2'(rg);
   endfunction

   always_comb begin
      if (size_ff == '0) begin
         eff_dim = DW'(1);
      end else if (32'(size_ff) > MAX_DIM) begin
         eff_dim = DW'(MAX_DIM);
      end else begin
         eff_dim = DW'(size_ff);
      end
   end

   assign req_r = IW'(req_chan.row);
   assign req_c = IW'(req_chan.col);

   assign req_chan.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign accept = req_chan.valid && req_chan.ready;

   assign load_hit = (32'(req_chan.row) < 32'(eff_dim)) && (32'(req_chan.col) < 32'(eff_dim));
   assign read_hit = load_hit;
   // Outside the last run's extent the result keeps its identity entries.
   assign read_ident = id_flag_ff || (32'(req_chan.row) >= 32'(run_dim_ff))
                       || (32'(req_chan.col) >= 32'(run_dim_ff));

   assign load_value = (req_chan.element_value >= MODULUS) ?
                       req_chan.element_value - MODULUS : req_chan.element_value;

   assign i_last = (DW'(i_ff) == run_dim_ff - DW'(1));
   assign j_last = (DW'(j_ff) == run_dim_ff - DW'(1));
   assign k_last = (DW'(k_ff) == run_dim_ff - DW'(1));

   // The left operand of a result multiply is the identity before the first one.
   assign opa = (mm_res_ff && id_flag_ff) ? ((i_ff == k_ff) ? ELEM_W'(1) : '0) : rd_data_a;
   assign mul_start = (state_ff == ST_MM_MUL);

   assign acc_sum  = {1'b0, acc_ff} + {1'b0, mul_res};
   assign acc_next = (acc_sum >= {1'b0, MODULUS}) ? ELEM_W'(acc_sum - {1'b0, MODULUS})
                                                 : ELEM_W'(acc_sum);

   // The response register is loaded when an answer is ready in this cycle.
   always_comb begin
      unique case (state_ff)
         ST_IDLE: begin
            rsp_set = accept && (req_chan.op != OP_RUN)
                      && !(req_chan.op == OP_READ && read_hit && !read_ident);
         end
         ST_RD_WAIT:   rsp_set = 1'b1;
         ST_RUN_CHECK: rsp_set = (ex_ff == '0);
         default:      rsp_set = 1'b0;
      endcase
   end

   always_comb begin
      rd_addr_a = {2'(REG_RESULT), req_r, req_c};
      rd_addr_b = {phys_region(REG_POWER, pow_base_ff), k_ff, j_ff};
      unique case (state_ff)
         ST_MM_RD: rd_addr_a = {phys_region(mm_res_ff ? REG_RESULT : REG_POWER, pow_base_ff),
                                i_ff, k_ff};
         ST_CP_RD: rd_addr_a = {2'(REG_SCRATCH), i_ff, j_ff};
         default:  rd_addr_a = {2'(REG_RESULT), req_r, req_c};
      endcase
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = {2'(REG_BASE), req_r, req_c};
      wr_data = load_value;
      unique case (state_ff)
         ST_IDLE: begin
            wr_en = accept && (req_chan.op == OP_LOAD) && load_hit;
         end
         ST_MM_WAIT: begin
            wr_en   = mul_done && k_last;
            wr_addr = {2'(REG_SCRATCH), i_ff, j_ff};
            wr_data = acc_next;
         end
         ST_CP_WR: begin
            wr_en   = 1'b1;
            wr_addr = {mm_res_ff ? 2'(REG_RESULT) : 2'(REG_POWER), i_ff, j_ff};
            wr_data = rd_data_a;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   mmp_mem #(.ADDR_W(AW)) u_mem (
      .clock        (clock),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .rd_addr_a    (rd_addr_a),
      .rd_addr_b    (rd_addr_b),
      .rd_data_a_ff (rd_data_a),
      .rd_data_b_ff (rd_data_b)
   );

   mmp_mulmod u_mulmod (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .a      (opa),
      .b      (rd_data_b),
      .done   (mul_done),
      .result (mul_res)
   );

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_W'(16);
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && csr_paddr[2] == CSR_IDX_MATRIX_SIZE) begin
         size_ff <= csr_pwdata[SIZE_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == CSR_IDX_MATRIX_SIZE) ? CSR_DATA_W'(size_ff) : '0;
   assign csr_pready = 1'b1;

   // Sequencer: request decode, multiply walk over i, j, k and the copy sweep.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         id_flag_ff   <= 1'b1;
         pow_base_ff  <= 1'b1;
         mm_res_ff    <= 1'b0;
         run_dim_ff   <= DW'(MAX_DIM);
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_set) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  unique case (req_chan.op)
                     OP_RUN: begin
                        rsp_value_ff   <= '0;
                        rsp_is_read_ff <= 1'b0;
                        id_flag_ff     <= 1'b1;
                        pow_base_ff    <= 1'b1;
                        ex_ff          <= req_chan.exponent;
                        run_dim_ff     <= eff_dim;
                        i_ff           <= '0;
                        j_ff           <= '0;
                        k_ff           <= '0;
                        acc_ff         <= '0;
                        state_ff       <= ST_RUN_CHECK;
                     end
                     OP_READ: begin
                        rsp_is_read_ff <= 1'b1;
                        if (read_hit && !read_ident) begin
                           state_ff <= ST_RD_WAIT;
                        end else begin
                           rsp_value_ff <= (read_hit && req_chan.row == req_chan.col) ?
                                           ELEM_W'(1) : '0;
                        end
                     end
                     default: begin
                        rsp_value_ff   <= '0;
                        rsp_is_read_ff <= 1'b0;
                     end
                  endcase
               end
            end
            ST_RD_WAIT: begin
               rsp_value_ff <= rd_data_a;
               state_ff     <= ST_IDLE;
            end
            ST_RUN_CHECK: begin
               if (ex_ff == '0) begin
                  state_ff <= ST_IDLE;
               end else begin
                  mm_res_ff <= ex_ff[0];
                  state_ff  <= ST_MM_RD;
               end
            end
            ST_MM_RD: begin
               state_ff <= ST_MM_MUL;
            end
            ST_MM_MUL: begin
               state_ff <= ST_MM_WAIT;
            end
            ST_MM_WAIT: begin
               if (mul_done) begin
                  state_ff <= (k_last && j_last && i_last) ? ST_CP_RD : ST_MM_RD;
                  if (k_last) begin
                     acc_ff <= '0;
                     k_ff   <= '0;
                     if (j_last) begin
                        j_ff <= '0;
                        if (i_last) begin
                           i_ff <= '0;
                        end else begin
                           i_ff <= i_ff + IW'(1);
                        end
                     end else begin
                        j_ff <= j_ff + IW'(1);
                     end
                  end else begin
                     acc_ff <= acc_next;
                     k_ff   <= k_ff + IW'(1);
                  end
               end
            end
            ST_CP_RD: begin
               state_ff <= ST_CP_WR;
            end
            ST_CP_WR: begin
               if (!(j_last && i_last)) begin
                  state_ff <= ST_CP_RD;
               end else if (mm_res_ff) begin
                  state_ff <= ST_MM_RD;
               end else begin
                  state_ff <= ST_RUN_CHECK;
               end
               if (j_last) begin
                  j_ff <= '0;
                  if (i_last) begin
                     i_ff <= '0;
                     if (mm_res_ff) begin
                        // Result updated; now square the running power.
                        id_flag_ff <= 1'b0;
                        mm_res_ff  <= 1'b0;
                     end else begin
                        pow_base_ff <= 1'b0;
                        ex_ff       <= ex_ff >> 1;
                     end
                  end else begin
                     i_ff <= i_ff + IW'(1);
                  end
               end else begin
                  j_ff <= j_ff + IW'(1);
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.result_value = rsp_value_ff;
   assign rsp_chan.is_read_data = rsp_is_read_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/mmp_mem.sv
// Matrix storage: one write port and two registered read ports.
`default_nettype none

module mmp_mem import mmp_pkg::*; #(
   parameter int ADDR_W = 10
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [ELEM_W-1:0] wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr_a,
   input  wire logic [ADDR_W-1:0] rd_addr_b,
   output logic      [ELEM_W-1:0] rd_data_a_ff,
   output logic      [ELEM_W-1:0] rd_data_b_ff
);

   logic [ELEM_W-1:0] mem_ff [2**ADDR_W];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem_ff[rd_addr_a];
      rd_data_b_ff <= mem_ff[rd_addr_b];
   end

endmodule

`default_nettype wire

FILE: hw/rtl/mmp_mulmod.sv
// Modular multiplier: product, Barrett quotient estimate and final corrections.
`default_nettype none

module mmp_mulmod import mmp_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [ELEM_W-1:0] a,
   input  wire logic [ELEM_W-1:0] b,
   output logic                   done,
   output logic      [ELEM_W-1:0] result
);

   logic [5:0]  stage_ff;
   logic [59:0] prod_ff;
   logic [61:0] est_ff;
   logic [31:0] qm_ff;
   logic [31:0] rem_ff;
   logic [31:0] fix_ff;
   logic [ELEM_W-1:0] res_ff;
   logic [30:0] quot;

   assign quot = est_ff[61:31];

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= {stage_ff[4:0], start};
      end
      if (start) begin
         prod_ff <= 60'(a) * 60'(b);
      end
      if (stage_ff[0]) begin
         est_ff <= 62'(prod_ff[59:29]) * 62'(BARRETT_MU);
      end
      if (stage_ff[1]) begin
         qm_ff <= 32'(quot) * 32'(MODULUS);
      end
      if (stage_ff[2]) begin
         rem_ff <= prod_ff[31:0] - qm_ff;
      end
      if (stage_ff[3]) begin
         fix_ff <= (rem_ff >= 32'(MODULUS)) ? rem_ff - 32'(MODULUS) : rem_ff;
      end
      if (stage_ff[4]) begin
         res_ff <= (fix_ff >= 32'(MODULUS)) ? ELEM_W'(fix_ff - 32'(MODULUS))
                                            : ELEM_W'(fix_ff);
      end
   end

   assign done   = stage_ff[5];
   assign result = res_ff;

endmodule

`default_nettype wire
